// File: sv/ppf_pkg.sv
// ---------------------------------------------------------------------------
// ppf_pkg
// Shared types and constants for the packet port filter.
// ---------------------------------------------------------------------------
package ppf_pkg;

   localparam int ROW_WIDTH   = 32;
   localparam int ROW_IDX_W   = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TABLE = 1'b1;

   localparam logic [6:0] OFFSET_MAX    = 7'd127;
   localparam logic [6:0] OFF_ETYPE_HI  = 7'd12;
   localparam logic [6:0] OFF_ETYPE_LO  = 7'd13;
   localparam logic [6:0] OFF_IHL       = 7'd14;
   localparam logic [6:0] OFF_PROTO     = 7'd23;
   localparam logic [6:0] OFF_PORT_BASE = 7'd16;

   localparam logic [7:0]  ETH_HDR_LEN  = 8'd14;
   localparam logic [7:0]  IPV4_MIN_LEN = 8'd34;
   localparam logic [7:0]  IP_HDR_MIN   = 8'd20;
   localparam logic [7:0]  TCP_HDR_LEN  = 8'd20;
   localparam logic [7:0]  UDP_HDR_LEN  = 8'd8;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;
   localparam logic [15:0] ETYPE_IPV4   = 16'h0800;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_PASS,
      OP_DROP,
      OP_LOOKUP
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] port;
      logic        block_bit;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

// File: sv/packet_port_filter.sv
// ---------------------------------------------------------------------------
// packet_port_filter
// Destination-port firewall for IPv4 TCP/UDP frames, one byte per beat.
// ---------------------------------------------------------------------------
// Takes one beat per clock, frame bytes and table writes alike, as long as
// the result side keeps up. The verdict for a frame passes through the queue,
// the table-read stage and the result register before it leaves rsp. After
// reset the blocked-port table is swept clear one 32-bit row per cycle, all
// ceil(PORT_TABLE_DEPTH/32) rows (2048 at the default depth), while
// req_stall stays high.
module packet_port_filter #(
   parameter int PORT_TABLE_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_last,
   input  logic [15:0] req_table_port,
   input  logic        req_block_bit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_drop
);
   import ppf_pkg::*;

   logic             push;
   logic             pop;
   logic             busy;
   logic             hold;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type qstat;

   assign hold = busy || qstat.full;

   ppf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_frame_byte (req_frame_byte),
      .req_frame_last (req_frame_last),
      .req_table_port (req_table_port),
      .req_block_bit  (req_block_bit),
      .hold           (hold),
      .push           (push),
      .entry          (push_entry)
   );

   ppf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (qstat)
   );

   ppf_back #(
      .PORT_TABLE_DEPTH (PORT_TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_drop  (rsp_drop)
   );

endmodule

// File: sv/ppf_front.sv
// ---------------------------------------------------------------------------
// ppf_front
// Byte parser: tracks the offset, captures header fields and classifies
// each frame on its last beat; table writes pass straight to the queue.
// ---------------------------------------------------------------------------
module ppf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [7:0]        req_frame_byte,
   input  logic              req_frame_last,
   input  logic [15:0]       req_table_port,
   input  logic              req_block_bit,
   input  logic              hold,
   output logic              push,
   output ppf_pkg::entry_type entry
);
   import ppf_pkg::*;

   logic [6:0]  offset_ff, offset_in;
   logic [15:0] etype_ff, etype_in;
   logic [3:0]  hlen_ff, hlen_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] dport_ff, dport_in;
   logic        accept;
   logic        frame_beat;
   logic [6:0]  port_at;
   logic [7:0]  frame_len;
   logic [7:0]  hdr_bytes;
   logic [7:0]  l4_at;
   op_type      verdict_op;

   assign req_stall  = hold;
   assign accept     = req_valid && !hold;
   assign frame_beat = accept && (req_kind == KIND_FRAME);

   always_comb begin
      etype_in = etype_ff;
      hlen_in  = hlen_ff;
      proto_in = proto_ff;
      dport_in = dport_ff;
      if (offset_ff == OFF_ETYPE_HI) begin
         etype_in = {req_frame_byte, etype_ff[7:0]};
      end else if (offset_ff == OFF_ETYPE_LO) begin
         etype_in = {etype_ff[15:8], req_frame_byte};
      end else if (offset_ff == OFF_IHL) begin
         hlen_in = req_frame_byte[3:0];
      end else if (offset_ff == OFF_PROTO) begin
         proto_in = req_frame_byte;
      end
      port_at = OFF_PORT_BASE + {1'b0, hlen_in, 2'b00};
      if (offset_ff > OFF_IHL) begin
         if (offset_ff == port_at) begin
            dport_in = {req_frame_byte, dport_ff[7:0]};
         end else if (offset_ff == port_at + 7'd1) begin
            dport_in = {dport_ff[15:8], req_frame_byte};
         end
      end
   end

   always_comb begin
      frame_len = {1'b0, offset_ff} + 8'd1;
      hdr_bytes = {2'b00, hlen_in, 2'b00};
      l4_at     = ETH_HDR_LEN + hdr_bytes;
      priority if (frame_len < ETH_HDR_LEN) begin
         verdict_op = OP_DROP;
      end else if (etype_in != ETYPE_IPV4) begin
         verdict_op = OP_PASS;
      end else if (frame_len < IPV4_MIN_LEN) begin
         verdict_op = OP_DROP;
      end else if (hdr_bytes < IP_HDR_MIN || l4_at > frame_len) begin
         verdict_op = OP_PASS;
      end else if (proto_in == PROTO_TCP) begin
         verdict_op = (l4_at + TCP_HDR_LEN > frame_len) ? OP_PASS : OP_LOOKUP;
      end else if (proto_in == PROTO_UDP) begin
         verdict_op = (l4_at + UDP_HDR_LEN > frame_len) ? OP_PASS : OP_LOOKUP;
      end else begin
         verdict_op = OP_PASS;
      end
   end

   always_comb begin
      offset_in = (offset_ff < OFFSET_MAX) ? offset_ff + 7'd1 : offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         etype_ff  <= '0;
         hlen_ff   <= '0;
         proto_ff  <= '0;
         dport_ff  <= '0;
      end else if (frame_beat) begin
         if (req_frame_last) begin
            offset_ff <= '0;
            etype_ff  <= '0;
            hlen_ff   <= '0;
            proto_ff  <= '0;
            dport_ff  <= '0;
         end else begin
            offset_ff <= offset_in;
            etype_ff  <= etype_in;
            hlen_ff   <= hlen_in;
            proto_ff  <= proto_in;
            dport_ff  <= dport_in;
         end
      end
   end

   always_comb begin
      push = accept && (req_kind == KIND_TABLE || req_frame_last);
      if (req_kind == KIND_TABLE) begin
         entry.op        = OP_WRITE;
         entry.port      = req_table_port;
         entry.block_bit = req_block_bit;
      end else begin
         entry.op        = verdict_op;
         entry.port      = dport_in;
         entry.block_bit = 1'b0;
      end
   end

   a_last_clears_offset: assert property (@(posedge clock) disable iff (reset)
      frame_beat && req_frame_last |=> offset_ff == 7'd0)
      else $error("offset not cleared after last beat");

endmodule

// File: sv/ppf_queue.sv
// ---------------------------------------------------------------------------
// ppf_queue
// Short in-order queue between the parser and the table stage.
// ---------------------------------------------------------------------------
module ppf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ppf_pkg::entry_type       push_entry,
   input  logic                     pop,
   output ppf_pkg::entry_type       head,
   output ppf_pkg::queue_status_type status
);
   import ppf_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign head             = slot_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !status.not_empty))
      else $error("queue pop while empty");

endmodule

// File: sv/ppf_back.sv
// ---------------------------------------------------------------------------
// ppf_back
// Blocked-port table with clearing sweep, lookup stage and result register.
// ---------------------------------------------------------------------------
module ppf_back #(
   parameter int PORT_TABLE_DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ppf_pkg::entry_type       head,
   input  ppf_pkg::queue_status_type qstat,
   output logic                     pop,
   output logic                     busy,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_drop
);
   import ppf_pkg::*;

   localparam int ROWS  = (PORT_TABLE_DEPTH + ROW_WIDTH - 1) / ROW_WIDTH;
   localparam int ROW_W = $clog2(ROWS);

   logic [ROW_WIDTH-1:0] table_ff [ROWS];
   logic                 clr_busy_ff;
   logic [ROW_W-1:0]     clr_row_ff;
   logic                 rd_bit_ff;
   logic                 s1_valid_ff, s1_valid_in;
   op_type               s1_op_ff;
   logic                 s1_in_range_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_drop_ff, rsp_drop_in;
   logic                 out_free;
   logic                 in_range;
   logic [ROW_W-1:0]     row;
   logic [ROW_IDX_W-1:0] bit_idx;
   logic                 s1_drop;

   assign busy     = clr_busy_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = qstat.not_empty && !clr_busy_ff && (!s1_valid_ff || out_free);
   assign in_range = {1'b0, head.port} < 17'(PORT_TABLE_DEPTH);
   assign row      = head.port[ROW_W+ROW_IDX_W-1:ROW_IDX_W];
   assign bit_idx  = head.port[ROW_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         table_ff[clr_row_ff] <= '0;
      end else if (pop && head.op == OP_WRITE && in_range) begin
         table_ff[row][bit_idx] <= head.block_bit;
      end
      if (pop && head.op == OP_LOOKUP && in_range) begin
         rd_bit_ff <= table_ff[row][bit_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clr_busy_ff) begin
         if (clr_row_ff == ROW_W'(ROWS - 1)) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_row_ff <= clr_row_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (pop && head.op != OP_WRITE) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      unique case (s1_op_ff)
         OP_DROP:   s1_drop = 1'b1;
         OP_LOOKUP: s1_drop = s1_in_range_ff && rd_bit_ff;
         OP_PASS:   s1_drop = 1'b0;
         OP_WRITE:  s1_drop = 1'b0;
         default:   s1_drop = 1'b0;
      endcase
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      rsp_drop_in  = out_free ? s1_drop : rsp_drop_ff;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff       <= head.op;
         s1_in_range_ff <= in_range;
      end
      rsp_drop_ff <= rsp_drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drop  = rsp_drop_ff;

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !pop)
      else $error("queue popped during table clear");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_op_ff))
      else $error("lookup stage lost while output blocked");

endmodule

// File: verif/packet_port_filter_tb.sv
// ---------------------------------------------------------------------------
// packet_port_filter_tb
// Self-checking bench for the destination-port firewall.
// ---------------------------------------------------------------------------
// Streams Ethernet frames and blocked-port table writes into req, one beat at
// a time. A behavioral copy of the byte parser and of the port table predicts
// each frame's verdict. Verdicts on rsp are checked in order against that
// prediction. Most frames are IPv4 TCP/UDP with lengths near the header
// limits, some long enough to saturate the offset counter. The rest are
// other protocols, other ethertypes, runts and noise. Table writes land
// between frames, inside frames and right behind a frame's last byte. Both
// sides idle at random, except for one stretch that runs at full rate.
module packet_port_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppf_pkg::*;

   localparam logic [15:0] HOT_PORTS [8] = '{16'd0, 16'd53, 16'd80, 16'd443,
                                             16'd8080, 16'hffff, 16'h8000, 16'h00ff};

   class verdict_scoreboard;
      bit        blocked [65536];
      bit [6:0]  offset;
      bit [15:0] etype;
      bit [3:0]  ihl;
      bit [7:0]  proto;
      bit [15:0] dport;
      bit        expected_drop [$];
      int        errors;
      int        frames;
      int        drops;
      int        lookups;
      int        long_frames;
      int        table_writes;

      function bit judge(int unsigned len);
         int unsigned l4;
         l4 = ETH_HDR_LEN + ihl * 4;
         if (len < ETH_HDR_LEN) return 1'b1;
         if (etype != ETYPE_IPV4) return 1'b0;
         if (len < IPV4_MIN_LEN) return 1'b1;
         if (ihl * 4 < IP_HDR_MIN || l4 > len) return 1'b0;
         if (proto == PROTO_TCP) begin
            if (l4 + TCP_HDR_LEN > len) return 1'b0;
         end else if (proto == PROTO_UDP) begin
            if (l4 + UDP_HDR_LEN > len) return 1'b0;
         end else begin
            return 1'b0;
         end
         lookups++;
         return blocked[dport];
      endfunction

      function void note_beat(logic kind, logic [7:0] data, logic last,
                              logic [15:0] port, logic blk);
         int unsigned port_at;
         bit          verdict;
         if (kind == KIND_TABLE) begin
            blocked[port] = blk;
            table_writes++;
            return;
         end
         case (offset)
            OFF_ETYPE_HI: etype[15:8] = data;
            OFF_ETYPE_LO: etype[7:0] = data;
            OFF_IHL:      ihl = data[3:0];
            OFF_PROTO:    proto = data;
            default: ;
         endcase
         port_at = ETH_HDR_LEN + ihl * 4 + 2;
         if (offset > ETH_HDR_LEN) begin
            if (offset == port_at) dport[15:8] = data;
            else if (offset == port_at + 1) dport[7:0] = data;
         end
         if (last) begin
            verdict = judge(offset + 1);
            expected_drop.push_back(verdict);
            frames++;
            drops += verdict;
            if (offset == OFFSET_MAX) long_frames++;
            offset = '0;
            etype = '0;
            ihl = '0;
            proto = '0;
            dport = '0;
         end else if (offset != OFFSET_MAX) begin
            offset++;
         end
      endfunction

      function void check_verdict(logic drop);
         bit want;
         if (expected_drop.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR at %0t: verdict drop=%0b with no frame outstanding",
                        $realtime, drop);
            return;
         end
         want = expected_drop.pop_front();
         if (drop !== want) begin
            errors++;
            if (errors <= 10)
               $display("ERROR at %0t: verdict expected drop=%0b, got drop=%0b",
                        $realtime, want, drop);
         end
      endfunction

      function int pending();
         return expected_drop.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [7:0]  req_frame_byte;
   logic        req_frame_last;
   logic [15:0] req_table_port;
   logic        req_block_bit;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_drop;

   verdict_scoreboard sb;
   int                beats = 0;
   bit                calm = 1'b0;
   logic [7:0]        frame_buf [$];
   logic [15:0]       frame_port = 16'd0;

   packet_port_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_frame_byte (req_frame_byte),
      .req_frame_last (req_frame_last),
      .req_table_port (req_table_port),
      .req_block_bit  (req_block_bit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drop       (rsp_drop)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("Timeout: verdicts still outstanding or req never drained");
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_stall <= !calm && $urandom_range(0, 99) < 30;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_verdict(rsp_drop);
   end

   function automatic logic [15:0] pick_port();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return HOT_PORTS[$urandom_range(0, 7)];
   endfunction

   task automatic send_beat(logic kind, logic [7:0] data, logic last,
                            logic [15:0] port, logic blk);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_frame_byte <= data;
      req_frame_last <= last;
      req_table_port <= port;
      req_block_bit  <= blk;
      do @(posedge clock); while (req_stall);
      sb.note_beat(kind, data, last, port, blk);
      beats++;
      calm = beats >= 600 && beats < 900;
   endtask

   task automatic write_port(logic [15:0] port, logic blk);
      send_beat(KIND_TABLE, 8'($urandom), 1'($urandom), port, blk);
   endtask

   // Frame shapes: mostly TCP/UDP near the length limits, plus other
   // protocols, other ethertypes, runts and plain noise.
   function automatic void build_frame();
      int unsigned pick;
      int unsigned ihl;
      int unsigned len;
      int unsigned l4;
      int unsigned need;
      logic [7:0]  proto;
      logic [15:0] etype_val;
      pick = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 9) < 8) ? 5 : $urandom_range(0, 15);
      proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
      frame_port = pick_port();
      etype_val = ETYPE_IPV4;
      l4 = 14 + ihl * 4;
      need = l4 + ((proto == PROTO_TCP) ? 20 : 8);
      if (pick < 60) begin
         case ($urandom_range(0, 5))
            0: len = need;
            1: len = need - 1;
            2: len = 96 + $urandom_range(0, 50);
            default: len = need + $urandom_range(0, 10);
         endcase
      end else if (pick < 70) begin
         proto = 8'($urandom);
         len = need + $urandom_range(0, 8);
      end else if (pick < 80) begin
         case ($urandom_range(0, 3))
            0: etype_val = 16'h0801;
            1: etype_val = 16'h0008;
            2: etype_val = 16'h86dd;
            default: etype_val = 16'($urandom);
         endcase
         len = $urandom_range(10, 60);
      end else begin
         len = $urandom_range(1, 34);
      end
      if (pick >= 95) len = $urandom_range(1, 80);
      frame_buf.delete();
      repeat (len) frame_buf.push_back(8'($urandom));
      if (pick < 95) begin
         if (len > 13) begin
            frame_buf[12] = etype_val[15:8];
            frame_buf[13] = etype_val[7:0];
         end
         if (len > 14) frame_buf[14] = {frame_buf[14][7:4], 4'(ihl)};
         if (len > 23) frame_buf[23] = proto;
         if (len > l4 + 3) begin
            frame_buf[l4 + 2] = frame_port[15:8];
            frame_buf[l4 + 3] = frame_port[7:0];
         end
      end
   endfunction

   task automatic send_frame();
      int n;
      int i;
      n = frame_buf.size();
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 4) write_port(pick_port(), 1'($urandom));
         send_beat(KIND_FRAME, frame_buf[i], i == n - 1, 16'($urandom), 1'($urandom));
      end
      // flip the frame's own port right behind its last byte
      if ($urandom_range(0, 99) < 15) write_port(frame_port, !sb.blocked[frame_port]);
   endtask

   initial begin
      sb = new;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_FRAME;
      req_frame_byte = '0;
      req_frame_last = 1'b0;
      req_table_port = '0;
      req_block_bit  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // port extremes blocked, then runts and a minimal non-IPv4 frame
      send_beat(KIND_TABLE, 8'h00, 1'b1, 16'h0000, 1'b1);
      send_beat(KIND_TABLE, 8'hff, 1'b0, 16'hffff, 1'b1);
      send_beat(KIND_FRAME, 8'hff, 1'b1, 16'hffff, 1'b1);
      frame_buf.delete();
      repeat (12) frame_buf.push_back(8'h00);
      frame_buf.push_back(8'h08);
      send_frame();
      frame_buf.delete();
      repeat (12) frame_buf.push_back(8'hff);
      frame_buf.push_back(8'h86);
      frame_buf.push_back(8'hdd);
      send_frame();

      while (beats < 1450) begin
         repeat ($urandom_range(0, 2)) write_port(pick_port(), $urandom_range(0, 9) < 6);
         build_frame();
         send_frame();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Run: %0d frames, %0d dropped, %0d judged by port lookup, %0d past offset 127.",
               sb.frames, sb.drops, sb.lookups, sb.long_frames);
      $display("     %0d table writes in %0d beats, %0d mismatches.",
               sb.table_writes, beats, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
